FILE: rtl/core/sha1_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared constants, the state machine type and the round functions.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Chain word initial values by index.
  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = H0;
      3'd1: v = H1;
      3'd2: v = H2;
      3'd3: v = H3;
      default: v = H4;
    endcase
    return v;
  endfunction

  // One SHA-1 round: returns the new a.
  function automatic logic [31:0] round_t(input logic [6:0] r, input logic [31:0] a,
                                          input logic [31:0] b, input logic [31:0] c,
                                          input logic [31:0] d, input logic [31:0] e,
                                          input logic [31:0] w);
    logic [31:0] f;
    logic [31:0] k;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    return {a[26:0], a[31:27]} + f + e + w + k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha1_wbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 message schedule buffer
// Sixteen-word memory holding the block; before the rounds it is read out
// word by word, in order, to load the schedule window.
// ----------------------------------------------------------------------------
module sha1_wbuf (
  input  wire        clk,
  input  wire        wr_en,
  input  wire [3:0]  wr_addr,
  input  wire [31:0] wr_data,
  input  wire [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/sha1_message_digest.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Streams 32-bit message words, pads the final block and returns the digest.
// ----------------------------------------------------------------------------
// A non-last item is written into the block memory, and the input stays
// open while the block fills. The sixteenth word of a block starts a
// compression: the sixteen words are read out of the block memory through
// its registered read into the schedule window, then come 80 rounds at one
// a cycle and the chaining add, all while the input is stalled. A last item
// adds padding (one word a cycle into the block memory), one or two
// compressions, then the five digest words leave one per accepted output
// item. The round rate is set by the single 32-bit adder chain of the round.
module sha1_message_digest (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_data_word,
  input  wire  [2:0]  in_valid_bytes,
  input  wire         in_last_word,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_digest_last
);

  sha1_pkg::state_t state_r, state_nxt;

  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] win_r [16];          // schedule window, index 0 = w[r]
  logic [6:0]  round_r;
  logic [3:0]  pos_r;
  logic [60:0] bytes_r;
  logic        final_r;             // a last item is being closed out
  logic        padded_r;            // the pad byte word has been written
  logic        lenhi_r;             // length high word is in this block
  logic [2:0]  emit_r;
  logic [4:0]  load_r;              // window load counter (0..17)

  logic        in_acc, out_acc;
  logic [2:0]  nb;
  logic [31:0] pad_word;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;
  logic [31:0] rd_data;
  logic [31:0] t_new, w_new;
  logic [63:0] bits;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign nb      = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign bits    = {bytes_r, 3'b000};

  // Padded partial word.
  always_comb begin
    case (nb)
      3'd1: pad_word = {in_data_word[31:24], sha1_pkg::PAD_BYTE, 16'h0};
      3'd2: pad_word = {in_data_word[31:16], sha1_pkg::PAD_BYTE, 8'h0};
      3'd3: pad_word = {in_data_word[31:8], sha1_pkg::PAD_BYTE};
      default: pad_word = {sha1_pkg::PAD_BYTE, 24'h0};
    endcase
  end

  // Memory write: input words and padding words.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = in_data_word;
    if (state_r == sha1_pkg::ST_IDLE && in_acc) begin
      wr_en = 1'b1;
      if (in_last_word && nb != 3'd4) begin
        wr_data = pad_word;
      end
    end else if (state_r == sha1_pkg::ST_PAD) begin
      wr_en = 1'b1;
      if (!padded_r) begin
        wr_data = {sha1_pkg::PAD_BYTE, 24'h0};
      end else if (pos_r == 4'd14) begin
        wr_data = bits[63:32];
      end else if (pos_r == 4'd15 && lenhi_r) begin
        wr_data = bits[31:0];
      end else begin
        wr_data = 32'h0;
      end
    end
  end

  sha1_wbuf u_wbuf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(load_r[3:0]),
    .rd_data(rd_data)
  );

  assign w_new = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign t_new = sha1_pkg::round_t(round_r, a_r, b_r, c_r, d_r, e_r, win_r[0]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (pos_r == 4'd15) begin
            state_nxt = sha1_pkg::ST_ROUND;
          end else if (in_last_word) begin
            state_nxt = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_ROUND: begin
        if (round_r == 7'd79) state_nxt = sha1_pkg::ST_ADD;
      end
      sha1_pkg::ST_ADD: begin
        if (!final_r) state_nxt = sha1_pkg::ST_IDLE;
        else if (lenhi_r) state_nxt = sha1_pkg::ST_EMIT;
        else state_nxt = sha1_pkg::ST_PAD;
      end
      sha1_pkg::ST_PAD: begin
        if (pos_r == 4'd15) state_nxt = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_EMIT: begin
        if (out_acc && emit_r == 3'd4) state_nxt = sha1_pkg::ST_IDLE;
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall         = (state_r != sha1_pkg::ST_IDLE);
    out_valid        = (state_r == sha1_pkg::ST_EMIT);
    out_digest_word  = h_r[emit_r];
    out_digest_index = emit_r;
    out_digest_last  = (emit_r == 3'd4);
  end

  // Control registers. The length words go in the first block whose
  // position 14 is reached after the pad byte word was written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha1_pkg::ST_IDLE;
      pos_r    <= 4'd0;
      bytes_r  <= 61'd0;
      final_r  <= 1'b0;
      padded_r <= 1'b0;
      lenhi_r  <= 1'b0;
      emit_r   <= 3'd0;
      round_r  <= 7'd0;
      load_r   <= 5'd0;
      for (int i = 0; i < 5; i++) h_r[i] <= sha1_pkg::init_word(3'(i));
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sha1_pkg::ST_IDLE: begin
          round_r <= 7'd0;
          load_r  <= 5'd0;
          if (in_acc) begin
            pos_r <= pos_r + 4'd1;
            if (in_last_word) begin
              bytes_r  <= bytes_r + 61'(nb);
              final_r  <= 1'b1;
              // A short or empty last word already carries the pad byte.
              padded_r <= (nb != 3'd4);
            end else begin
              bytes_r <= bytes_r + 61'd4;
            end
          end
        end
        sha1_pkg::ST_ROUND: begin
          if (load_r != 5'd17) load_r <= load_r + 5'd1;
          else if (round_r != 7'd79) round_r <= round_r + 7'd1;
        end
        sha1_pkg::ST_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          round_r <= 7'd0;
          load_r  <= 5'd0;
        end
        sha1_pkg::ST_PAD: begin
          pos_r <= pos_r + 4'd1;
          if (!padded_r) padded_r <= 1'b1;
          else if (pos_r == 4'd14) lenhi_r <= 1'b1;
        end
        sha1_pkg::ST_EMIT: begin
          if (out_acc) begin
            emit_r <= emit_r + 3'd1;
            if (emit_r == 3'd4) begin
              emit_r   <= 3'd0;
              pos_r    <= 4'd0;
              bytes_r  <= 61'd0;
              final_r  <= 1'b0;
              padded_r <= 1'b0;
              lenhi_r  <= 1'b0;
              for (int i = 0; i < 5; i++) h_r[i] <= sha1_pkg::init_word(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk) begin
    if (state_r == sha1_pkg::ST_ROUND) begin
      if (load_r == 5'd0) begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
      end
      if (load_r >= 5'd1 && load_r <= 5'd16) begin
        for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
        win_r[15] <= rd_data;
      end else if (load_r == 5'd17) begin
        a_r <= t_new;
        b_r <= a_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        d_r <= c_r;
        e_r <= d_r;
        for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
        win_r[15] <= {w_new[30:0], w_new[31]};
      end
    end
  end

`ifndef SYNTH
  // Input is only taken while idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == sha1_pkg::ST_IDLE) else $error("input taken while busy");
  // Digest index advances by one per accepted output.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && emit_r != 3'd4 |=> emit_r == $past(emit_r) + 3'd1)
    else $error("digest index skipped");
  // Rounds never pass 79.
  assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= 7'd79) else $error("round overrun");
`endif

endmodule
`default_nettype wire

FILE: test/tb_sha1_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams messages of random and edge-case lengths into the block, keeps a
// behavioral SHA-1 of its own and checks every digest word, index and flag
// against it, with random idle bursts on both channels and a long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_data_word;
  logic [2:0]  in_valid_bytes;
  logic        in_last_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_digest_index;
  logic        out_digest_last;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  // Predictor state.
  logic [31:0] hash_chain [5];
  logic [31:0] msg_block [16];
  logic [4:0]  fill_pos;
  logic [60:0] msg_bytes;

  digest_item_t digest_queue [$];
  int  errors;
  int  cycle_count;
  bit  idle_enable;
  bit  hold_off;
  int  sent_words;

  sha1_message_digest uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_word(in_data_word), .in_valid_bytes(in_valid_bytes),
    .in_last_word(in_last_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_digest_index(out_digest_index),
    .out_digest_last(out_digest_last)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic chain_reset();
    hash_chain[0] = 32'h67452301;
    hash_chain[1] = 32'hefcdab89;
    hash_chain[2] = 32'h98badcfe;
    hash_chain[3] = 32'h10325476;
    hash_chain[4] = 32'hc3d2e1f0;
  endtask

  // Standard 80-round compression of the buffered block.
  task automatic compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = msg_block[r];
    for (int r = 16; r < 80; r++) w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
    d = hash_chain[3]; e = hash_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + w[r] + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
    hash_chain[3] += d; hash_chain[4] += e;
  endtask

  task automatic block_push(input logic [31:0] w);
    msg_block[fill_pos[3:0]] = w;
    fill_pos = fill_pos + 5'd1;
    if (fill_pos >= 5'd16) begin
      compress_block();
      fill_pos = '0;
    end
  endtask

  // Predicts the effect of one accepted item.
  task automatic predict_digest(input logic [31:0] data, input logic [2:0] nb,
                                input logic last);
    int n;
    logic [31:0] pad, keep;
    logic [63:0] bits;
    digest_item_t it;
    n = int'(nb);
    if (n > 4 || !last) n = 4;
    if (!last) begin
      block_push(data);
      msg_bytes = msg_bytes + 61'd4;
    end else begin
      msg_bytes = msg_bytes + 61'(n);
      if (n == 4) begin
        block_push(data);
        pad = 32'h80000000;
      end else if (n == 0) begin
        pad = 32'h80000000;
      end else begin
        keep = 32'hFFFFFFFF << (32 - 8 * n);
        pad = (data & keep) | (32'h80 << (24 - 8 * n));
      end
      block_push(pad);
      while (fill_pos != 5'd14) block_push(32'h0);
      bits = {msg_bytes, 3'b000};
      block_push(bits[63:32]);
      block_push(bits[31:0]);
      for (int i = 0; i < 5; i++) begin
        it.word = hash_chain[i];
        it.index = i[2:0];
        it.last = (i == 4);
        digest_queue.push_back(it);
      end
      chain_reset();
      fill_pos = '0;
      msg_bytes = '0;
    end
  endtask

  // Sends one item, with an optional random idle burst first.
  task automatic send_word(input logic [31:0] data, input logic [2:0] nb,
                           input logic last);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_data_word   = data;
    in_valid_bytes = nb;
    in_last_word   = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(data, nb, last);
    sent_words++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Message of full words, then a last word with the given byte count.
  task automatic send_message(input int full_words, input logic [2:0] tail_bytes);
    for (int i = 0; i < full_words; i++)
      send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom(), tail_bytes, 1'b1);
  endtask

  task automatic test_directed();
    send_word(32'h61626300, 3'd3, 1'b1);      // "abc"
    send_word(32'h00000000, 3'd0, 1'b1);      // empty message
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    send_word(32'hFFFFFFFF, 3'd7, 1'b1);      // oversized count treated as four
    send_word(32'h12345678, 3'd1, 1'b0);      // short word that is not last
    send_word(32'hABCDEF01, 3'd2, 1'b1);
    send_message(13, 3'd4);                   // pad word lands at 14, two blocks
    send_message(12, 3'd3);                   // length fits in one block
    send_message(14, 3'd0);                   // empty tail right at the boundary
    send_message(15, 3'd2);                   // pad word fills the last slot
    send_message(15, 3'd5);
  endtask

  task automatic test_random();
    int n;
    while (sent_words < 160) begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(30, 40);
      else n = $urandom_range(0, 18);
      send_message(n, 3'($urandom_range(0, 7)));
    end
  endtask

  // Output blocked for a long stretch while input keeps coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      send_message(40, 3'd2);
      begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    send_message(3, 3'd4);
  endtask

  task automatic test_no_idle();
    idle_enable = 1'b0;
    for (int m = 0; m < 4; m++)
      send_message($urandom_range(0, 20), 3'($urandom_range(0, 4)));
  endtask

  // Receiver stall generator.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end else out_stall <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    digest_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest item %h", out_digest_word);
        errors++;
      end else begin
        exp_item = digest_queue.pop_front();
        if (out_digest_word !== exp_item.word) begin
          $error("digest_word expected %h actual %h", exp_item.word, out_digest_word);
          errors++;
        end
        if (out_digest_index !== exp_item.index) begin
          $error("digest_index expected %0d actual %0d", exp_item.index, out_digest_index);
          errors++;
        end
        if (out_digest_last !== exp_item.last) begin
          $error("digest_last expected %0d actual %0d", exp_item.last, out_digest_last);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycle_count = 0;
    sent_words = 0;
    idle_enable = 1'b1;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_word = '0;
    in_valid_bytes = '0;
    in_last_word = 1'b0;
    chain_reset();
    fill_pos = '0;
    msg_bytes = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_no_idle();
    while (digest_queue.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
